FILE: rtl/ardet_pkg.sv
// shared constants, types and command/status structs of the action rate anomaly detector
package ardet_pkg;

	// sizing
	localparam int USERS         = 16;
	localparam int HISTORY_DEPTH = 16;
	localparam int ENTRIES       = USERS * HISTORY_DEPTH;
	localparam int USER_W        = (USERS > 1) ? $clog2(USERS) : 1;
	localparam int SLOT_W        = $clog2(HISTORY_DEPTH);
	localparam int ADDR_W        = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
	localparam int CNT_W         = $clog2(HISTORY_DEPTH + 1);

	// field widths
	localparam int USER_ID_W  = 8;
	localparam int KIND_W     = 2;
	localparam int TIME_W     = 32;
	localparam int LIMIT_W    = 8;
	localparam int WINDOW_W   = 16;
	localparam int COUNT_W    = 5;
	localparam int CFG_IDX_W  = 2;
	localparam int CFG_DATA_W = 16;
	localparam int ENTRY_W    = KIND_W + TIME_W;

	// register reset values
	localparam logic [LIMIT_W-1:0]  DELETE_LIMIT_RST   = 8'd5;
	localparam logic [LIMIT_W-1:0]  MODIFY_LIMIT_RST   = 8'd10;
	localparam logic [WINDOW_W-1:0] WINDOW_SECONDS_RST = 16'd60;

	// largest value the count field can show
	localparam logic [COUNT_W-1:0] COUNT_SAT = 5'd31;

	// register indexes
	localparam logic [CFG_IDX_W-1:0] CFG_DELETE_LIMIT   = 2'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_MODIFY_LIMIT   = 2'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_WINDOW_SECONDS = 2'd2;

	// action kinds
	typedef enum logic [KIND_W-1:0] {
		KIND_OTHER  = 2'd0,
		KIND_DELETE = 2'd1,
		KIND_MODIFY = 2'd2
	} kind_t;

	// controller states
	typedef enum logic [1:0] {
		ST_IDLE,
		ST_SCAN,
		ST_DRAIN,
		ST_DECIDE
	} state_t;

	// controller to datapath
	typedef struct packed {
		logic load;
		logic rd_en;
		logic finish;
	} ardet_cmd_t;

	// datapath to controller
	typedef struct packed {
		logic scan_last;
	} ardet_status_t;

endpackage

FILE: rtl/ardet_ctrl.sv
// controller state machine: accepts an item, sequences the history scan, hands off the result
module ardet_ctrl (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  in_valid,
	output logic                  in_ready,
	output logic                  out_valid,
	input  logic                  out_ready,
	output ardet_pkg::ardet_cmd_t cmd,
	input  ardet_pkg::ardet_status_t status
);
	import ardet_pkg::*;

	state_t state_q;
	state_t state_nxt;
	logic   out_valid_q;
	logic   out_free;

	// output register can take a new result
	assign out_free = !out_valid_q || out_ready;

	// next state
	always_comb begin
		state_nxt = state_q;
		case (state_q)
			ST_IDLE: begin
				if (in_valid) state_nxt = ST_SCAN;
			end
			ST_SCAN: begin
				if (status.scan_last) state_nxt = ST_DRAIN;
			end
			ST_DRAIN: begin
				state_nxt = ST_DECIDE;
			end
			ST_DECIDE: begin
				if (out_free) state_nxt = ST_IDLE;
			end
			default: begin
				state_nxt = ST_IDLE;
			end
		endcase
	end

	// outputs and commands
	always_comb begin
		in_ready   = 1'b0;
		cmd.load   = 1'b0;
		cmd.rd_en  = 1'b0;
		cmd.finish = 1'b0;
		case (state_q)
			ST_IDLE: begin
				in_ready = 1'b1;
				cmd.load = in_valid;
			end
			ST_SCAN: begin
				cmd.rd_en = 1'b1;
			end
			ST_DRAIN: begin
			end
			ST_DECIDE: begin
				cmd.finish = out_free;
			end
			default: begin
			end
		endcase
	end

	// state register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_nxt;
		end
	end

	// result valid: set when a result is loaded, cleared on transfer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.finish) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	assign out_valid = out_valid_q;

endmodule

FILE: rtl/ardet_dp.sv
// datapath: config registers, history memory, ring pointers, window counters and result register
module ardet_dp (
	input  logic                                clk,
	input  logic                                arst_n,
	input  ardet_pkg::ardet_cmd_t               cmd,
	output ardet_pkg::ardet_status_t            status,
	input  logic [ardet_pkg::USER_ID_W-1:0]     user_id,
	input  logic [ardet_pkg::KIND_W-1:0]        action_kind,
	input  logic [ardet_pkg::TIME_W-1:0]        current_time,
	input  logic                                user_confirms,
	input  logic                                cfg_we,
	input  logic [ardet_pkg::CFG_IDX_W-1:0]     cfg_index,
	input  logic [ardet_pkg::CFG_DATA_W-1:0]    cfg_data,
	output logic                                anomaly,
	output logic                                blocked,
	output logic [ardet_pkg::COUNT_W-1:0]       recent_count
);
	import ardet_pkg::*;

	// config registers
	logic [LIMIT_W-1:0]  delete_limit_q;
	logic [LIMIT_W-1:0]  modify_limit_q;
	logic [WINDOW_W-1:0] window_q;

	// item registers
	logic [USER_W-1:0] uidx_q;
	logic              in_range_q;
	logic [KIND_W-1:0] kind_q;
	logic [TIME_W-1:0] now_q;
	logic              confirm_q;
	logic [ADDR_W-1:0] base_q;

	// scan state
	logic [SLOT_W-1:0]  slot_q;
	logic               rd_s1;
	logic [ENTRY_W-1:0] rd_data_s1;
	logic               rd_vld_s1;
	logic [CNT_W-1:0]   del_cnt_q;
	logic [CNT_W-1:0]   mod_cnt_q;

	// history storage
	logic [ENTRY_W-1:0] mem [ENTRIES];
	logic [ENTRIES-1:0] valid_q;
	logic [SLOT_W-1:0]  ptr_q [USERS];

	// result register
	logic               anomaly_q;
	logic               blocked_q;
	logic [COUNT_W-1:0] count_q;

	logic [USER_W-1:0] uidx_in;
	logic              in_range_in;
	logic [ADDR_W-1:0] rd_addr;
	logic [ADDR_W-1:0] wr_addr;
	logic [SLOT_W-1:0] ptr_cur;
	logic [SLOT_W-1:0] ptr_nxt;
	logic              wr_en;
	logic [TIME_W-1:0] ent_time;
	logic [KIND_W-1:0] ent_kind;
	logic [TIME_W-1:0] age;
	logic              hit;
	logic [CNT_W-1:0]  sel_cnt;
	logic [31:0]       sel_cnt32;
	logic              anomaly_c;
	logic              blocked_c;
	logic [COUNT_W-1:0] count_c;

	// config writes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			delete_limit_q <= DELETE_LIMIT_RST;
			modify_limit_q <= MODIFY_LIMIT_RST;
			window_q       <= WINDOW_SECONDS_RST;
		end else if (cfg_we) begin
			case (cfg_index)
				CFG_DELETE_LIMIT:   delete_limit_q <= cfg_data[LIMIT_W-1:0];
				CFG_MODIFY_LIMIT:   modify_limit_q <= cfg_data[LIMIT_W-1:0];
				CFG_WINDOW_SECONDS: window_q       <= cfg_data[WINDOW_W-1:0];
				default: begin
				end
			endcase
		end
	end

	// user decode
	assign uidx_in     = user_id[USER_W-1:0];
	assign in_range_in = ({1'b0, user_id} < (USER_ID_W + 1)'(USERS));

	// item capture on input transfer; kind three folds into other
	always_ff @(posedge clk) begin
		if (cmd.load) begin
			uidx_q     <= uidx_in;
			in_range_q <= in_range_in;
			kind_q     <= (action_kind == KIND_DELETE || action_kind == KIND_MODIFY) ?
				action_kind : KIND_OTHER;
			now_q      <= current_time;
			confirm_q  <= user_confirms;
			base_q     <= ADDR_W'(uidx_in) * ADDR_W'(HISTORY_DEPTH);
		end
	end

	// slot counter over the user's ring
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			slot_q <= '0;
		end else if (cmd.load) begin
			slot_q <= '0;
		end else if (cmd.rd_en) begin
			slot_q <= slot_q + SLOT_W'(1);
		end
	end

	assign status.scan_last = (slot_q == SLOT_W'(HISTORY_DEPTH - 1));
	assign rd_addr          = base_q + ADDR_W'(slot_q);

	// read pipeline flag
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rd_s1 <= 1'b0;
		end else begin
			rd_s1 <= cmd.rd_en;
		end
	end

	// ring pointer and write address
	assign ptr_cur = ptr_q[uidx_q];
	assign ptr_nxt = (ptr_cur == SLOT_W'(HISTORY_DEPTH - 1)) ? '0 : ptr_cur + SLOT_W'(1);
	assign wr_addr = base_q + ADDR_W'(ptr_cur);
	assign wr_en   = cmd.finish && in_range_q && !blocked_c;

	// history memory: one write, one registered read
	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= {kind_q, now_q};
		end
		if (cmd.rd_en) begin
			rd_data_s1 <= mem[rd_addr];
			rd_vld_s1  <= valid_q[rd_addr];
		end
	end

	// entry valid bits, cleared at reset
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= '0;
		end else if (wr_en) begin
			valid_q[wr_addr] <= 1'b1;
		end
	end

	// ring pointers, cleared at reset
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int u = 0; u < USERS; u++) begin
				ptr_q[u] <= '0;
			end
		end else if (wr_en) begin
			ptr_q[uidx_q] <= ptr_nxt;
		end
	end

	// window test on the entry just read
	assign ent_time = rd_data_s1[TIME_W-1:0];
	assign ent_kind = rd_data_s1[ENTRY_W-1:TIME_W];
	assign age      = now_q - ent_time;
	assign hit      = rd_s1 && rd_vld_s1 && (ent_time != '0) &&
		(age < {{(TIME_W - WINDOW_W){1'b0}}, window_q});

	// recent counts per kind
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			del_cnt_q <= '0;
			mod_cnt_q <= '0;
		end else if (cmd.load) begin
			del_cnt_q <= '0;
			mod_cnt_q <= '0;
		end else if (hit) begin
			if (ent_kind == KIND_DELETE) del_cnt_q <= del_cnt_q + CNT_W'(1);
			if (ent_kind == KIND_MODIFY) mod_cnt_q <= mod_cnt_q + CNT_W'(1);
		end
	end

	// decision
	always_comb begin
		sel_cnt   = '0;
		anomaly_c = 1'b0;
		case (kind_q)
			KIND_DELETE: begin
				sel_cnt   = del_cnt_q;
				anomaly_c = 32'(del_cnt_q) >= 32'(delete_limit_q);
			end
			KIND_MODIFY: begin
				sel_cnt   = mod_cnt_q;
				anomaly_c = 32'(mod_cnt_q) >= 32'(modify_limit_q);
			end
			default: begin
			end
		endcase
		if (!in_range_q) begin
			sel_cnt   = '0;
			anomaly_c = 1'b0;
		end
		sel_cnt32 = 32'(sel_cnt);
		count_c   = (sel_cnt32 > 32'(COUNT_SAT)) ? COUNT_SAT : sel_cnt32[COUNT_W-1:0];
		blocked_c = anomaly_c && !confirm_q;
	end

	// result register
	always_ff @(posedge clk) begin
		if (cmd.finish) begin
			anomaly_q <= anomaly_c;
			blocked_q <= blocked_c;
			count_q   <= count_c;
		end
	end

	assign anomaly      = anomaly_q;
	assign blocked      = blocked_q;
	assign recent_count = count_q;

endmodule

FILE: rtl/action_rate_anomaly_detector_core.sv
// Action rate anomaly detector: for each action, counts the user's recent history entries of the
// same kind inside a sliding time window, flags deletes or modifies that reach their limit, blocks
// unconfirmed anomalies, and records every other in-range action in a per-user ring. An item is
// taken, then each history slot of the user's ring is read in turn from the history memory, the
// last read lands, and a decide step writes back and loads the result register once the output
// register is free. A finished result waits in its own register while the next item is already
// taken and scanned. History is empty right after reset with no clearing pass; configuration
// writes take effect at once.
module action_rate_anomaly_detector_core (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              in_valid,
	output logic                              in_ready,
	input  logic [ardet_pkg::USER_ID_W-1:0]   user_id,
	input  logic [ardet_pkg::KIND_W-1:0]      action_kind,
	input  logic [ardet_pkg::TIME_W-1:0]      current_time,
	input  logic                              user_confirms,
	output logic                              out_valid,
	input  logic                              out_ready,
	output logic                              anomaly,
	output logic                              blocked,
	output logic [ardet_pkg::COUNT_W-1:0]     recent_count,
	input  logic                              cfg_we,
	input  logic [ardet_pkg::CFG_IDX_W-1:0]   cfg_index,
	input  logic [ardet_pkg::CFG_DATA_W-1:0]  cfg_data
);
	import ardet_pkg::*;

	ardet_cmd_t    cmd;
	ardet_status_t status;

	// sequencer
	ardet_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.cmd       (cmd),
		.status    (status)
	);

	// history and decision datapath
	ardet_dp u_dp (
		.clk           (clk),
		.arst_n        (arst_n),
		.cmd           (cmd),
		.status        (status),
		.user_id       (user_id),
		.action_kind   (action_kind),
		.current_time  (current_time),
		.user_confirms (user_confirms),
		.cfg_we        (cfg_we),
		.cfg_index     (cfg_index),
		.cfg_data      (cfg_data),
		.anomaly       (anomaly),
		.blocked       (blocked),
		.recent_count  (recent_count)
	);

endmodule

FILE: rtl/ardet_checker.sv
// port-level checks of the action rate anomaly detector, bound to the top level
module ardet_checker (
	input logic clk,
	input logic arst_n,
	input logic in_valid,
	input logic in_ready,
	input logic out_valid,
	input logic out_ready,
	input logic anomaly,
	input logic blocked
);

	// a result held back stays offered
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid)
		else $error("result dropped while stalled");

	// one item at a time: busy right after an input transfer
	a_busy_after_take: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready |=> !in_ready)
		else $error("input taken while an item is in flight");

	// only an anomaly can be blocked
	a_block_needs_anomaly: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && blocked |-> anomaly)
		else $error("blocked without anomaly");

	// a new result appears only while the input side is busy
	a_result_while_busy: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid) |-> $past(!in_ready))
		else $error("result raised without an item in flight");

endmodule

bind action_rate_anomaly_detector_core ardet_checker u_ardet_checker (.*);
